>>> sv/srb_pkg.sv
// ----------------------------------------------------------------------------
// Sequence reorder buffer package
// Result status codes, fixed field widths and the command and status groups
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package srb_pkg;

  localparam int unsigned SeqBits  = 32;
  localparam int unsigned DataBits = 32;
  localparam int unsigned MaxOut   = 16;
  localparam int unsigned CntBits  = 5;

  typedef enum logic [1:0] {
    ST_RELEASED = 2'd0,
    ST_HELD     = 2'd1,
    ST_STALE    = 2'd2,
    ST_BEYOND   = 2'd3
  } status_e;

  typedef struct packed {
    logic capture;
    logic store;
    logic read;
  } dp_cmd_t;

  typedef struct packed {
    logic rel_now;
    logic last;
  } dp_stat_t;

endpackage

>>> sv/srb_ctrl.sv
// ----------------------------------------------------------------------------
// Sequence reorder buffer controller
// Sequences capture, classification and store, slot reads and the hand-off of
// each result to the output channel.
// ----------------------------------------------------------------------------
module srb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output srb_pkg::dp_cmd_t cmd_o,
  input  srb_pkg::dp_stat_t stat_i
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_STORE = 4'b0010,
    S_READ  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_STORE;
        end
      end
      S_STORE: begin
        cmd_o.store = 1'b1;
        // A request that lands on the expected number goes straight to release.
        state_d = stat_i.rel_now ? S_READ : S_EMIT;
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = stat_i.last ? S_IDLE : S_READ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> sv/srb_dp.sv
// ----------------------------------------------------------------------------
// Sequence reorder buffer datapath
// Expected-number counter, slot ring with valid bits and payload memory, and
// the output register for one result.
// ----------------------------------------------------------------------------
module srb_dp #(
  parameter int unsigned WINDOW    = 16,
  parameter int unsigned StoreBits = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  srb_pkg::dp_cmd_t              cmd_i,
  output srb_pkg::dp_stat_t             stat_o,
  input  logic [srb_pkg::SeqBits-1:0]   seq_number_i,
  input  logic [srb_pkg::DataBits-1:0]  payload_i,
  input  logic                          cfg_we_i,
  input  logic [srb_pkg::SeqBits-1:0]   cfg_wdata_i,
  output logic [srb_pkg::SeqBits-1:0]   out_seq_number_o,
  output logic [srb_pkg::DataBits-1:0]  out_payload_o,
  output srb_pkg::status_e              status_o,
  output logic                          last_o
);

  localparam int unsigned HW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic [srb_pkg::SeqBits-1:0] seq_q;
  logic [StoreBits-1:0]        pay_q;
  logic [srb_pkg::SeqBits-1:0] next_q;
  logic [HW-1:0]               head_q;
  logic [WINDOW-1:0]           valid_q;
  logic [srb_pkg::CntBits-1:0] cnt_q;
  logic [StoreBits-1:0]        mem [WINDOW];
  logic [StoreBits-1:0]        rd_q;
  logic [srb_pkg::SeqBits-1:0] oseq_q;
  srb_pkg::status_e            ostat_q;
  logic                        olast_q;

  logic [srb_pkg::SeqBits-1:0] seq_off;
  logic                        in_win;
  logic                        rel_now;
  logic [HW:0]                 sum;
  logic [HW-1:0]               widx;
  logic [HW-1:0]               head_nx;
  logic [srb_pkg::CntBits-1:0] cnt_nx;

  assign seq_off = seq_q - next_q;
  assign in_win  = seq_off < srb_pkg::SeqBits'(WINDOW);
  assign rel_now = in_win && (seq_off == '0);
  // Both terms are below the window, so one conditional subtract wraps the ring.
  assign sum     = {1'b0, head_q} + {1'b0, seq_off[HW-1:0]};
  assign widx    = (sum >= (HW+1)'(WINDOW)) ? HW'(sum - (HW+1)'(WINDOW)) : sum[HW-1:0];
  assign head_nx = (head_q == HW'(WINDOW - 1)) ? '0 : head_q + 1'b1;
  assign cnt_nx  = cnt_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_q  <= '0;
      head_q  <= '0;
      valid_q <= '0;
      cnt_q   <= '0;
      olast_q <= 1'b1;
    end else begin
      if (cmd_i.store) begin
        if (in_win) begin
          valid_q[widx] <= 1'b1;
        end
        cnt_q   <= rel_now ? '0 : srb_pkg::CntBits'(1);
        // A held slot can only sit at the head when an earlier burst was capped.
        olast_q <= !valid_q[head_q];
      end
      if (cmd_i.read) begin
        valid_q[head_q] <= 1'b0;
        next_q          <= next_q + 1'b1;
        head_q          <= head_nx;
        cnt_q           <= cnt_nx;
        olast_q         <= !(valid_q[head_nx] && (cnt_nx < srb_pkg::CntBits'(srb_pkg::MaxOut)));
      end else if (cfg_we_i && !(|valid_q)) begin
        next_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      seq_q <= seq_number_i;
      pay_q <= payload_i[StoreBits-1:0];
    end
    if (cmd_i.store) begin
      oseq_q <= seq_q;
      if (in_win) begin
        ostat_q <= srb_pkg::ST_HELD;
      end else if (seq_off[srb_pkg::SeqBits-1]) begin
        ostat_q <= srb_pkg::ST_STALE;
      end else begin
        ostat_q <= srb_pkg::ST_BEYOND;
      end
    end
    if (cmd_i.read) begin
      oseq_q  <= next_q;
      ostat_q <= srb_pkg::ST_RELEASED;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store && in_win) begin
      mem[widx] <= pay_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      rd_q <= mem[head_q];
    end
  end

  assign stat_o.rel_now = rel_now;
  assign stat_o.last    = olast_q;

  assign out_seq_number_o = oseq_q;
  assign out_payload_o    = (ostat_q == srb_pkg::ST_RELEASED) ?
                            srb_pkg::DataBits'(rd_q) : '0;
  assign status_o         = ostat_q;
  assign last_o           = olast_q;

`ifndef SYNTHESIS
  a_read_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.read |-> valid_q[head_q])
    else $error("release read of an empty slot");

  a_read_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.read |=> !valid_q[$past(head_q)])
    else $error("released slot still marked held");

  a_burst_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= srb_pkg::CntBits'(srb_pkg::MaxOut))
    else $error("result count beyond burst cap");

  a_cfg_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && !(|valid_q) && !cmd_i.read |=> next_q == $past(cfg_wdata_i))
    else $error("start sequence not loaded while idle");
`endif

endmodule

>>> sv/sequence_reorder_buffer_unit.sv
// ----------------------------------------------------------------------------
// Sequence reorder buffer
// Stores out-of-order packets in a window of slots and releases them in
// sequence order, flagging stale and beyond-window packets.
// ----------------------------------------------------------------------------
// Usage: packets enter on the in_valid_i/in_ready_o request channel with a
// sequence number and a payload word. Each request yields one to sixteen
// results on the out_valid_o/out_ready_i channel; last_o marks the final one.
// A packet off the expected number first gives a held, stale or beyond result,
// then every consecutive held packet is released with status released.
// Timing: the accepting edge captures the request and the next edge classifies
// and stores it; its first result is offered right after the store, or after
// a payload memory read when it is released at once. Each release takes a
// payload memory read state and then an output state, and the block takes
// no new request before all results of the current one have gone out.
// The next request is taken once the last result has been delivered.
// A stalled receiver simply holds the current result; nothing is lost.
// cfg_we_i loads cfg_wdata_i as the next expected number when no slot is held.
// Reset clears all slots and sets the expected number to zero.
// ----------------------------------------------------------------------------
module sequence_reorder_buffer_unit #(
  parameter int unsigned WINDOW       = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [srb_pkg::SeqBits-1:0]  seq_number_i,
  input  logic [srb_pkg::DataBits-1:0] payload_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [srb_pkg::SeqBits-1:0]  out_seq_number_o,
  output logic [srb_pkg::DataBits-1:0] out_payload_o,
  output logic [1:0]                   status_o,
  output logic                         last_o,
  input  logic                         cfg_we_i,
  input  logic [srb_pkg::SeqBits-1:0]  cfg_wdata_i
);

  // Payload bits above the output width can never be seen, so are not stored.
  localparam int unsigned StoreBits =
    (PAYLOAD_BITS < srb_pkg::DataBits) ? PAYLOAD_BITS : srb_pkg::DataBits;

  srb_pkg::dp_cmd_t  cmd;
  srb_pkg::dp_stat_t stat;
  srb_pkg::status_e  status;

  srb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  srb_dp #(
    .WINDOW    (WINDOW),
    .StoreBits (StoreBits)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .seq_number_i     (seq_number_i),
    .payload_i        (payload_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .out_seq_number_o (out_seq_number_o),
    .out_payload_o    (out_payload_o),
    .status_o         (status),
    .last_o           (last_o)
  );

  assign status_o = status;

endmodule

>>> test/tb_sequence_reorder_buffer_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sequence reorder buffer testbench
// Drives packet requests through the reorder buffer and predicts every
// result it should return: held, stale and beyond-window flags followed by
// the in-order releases. A directed part covers the field extremes, the
// 32-bit wrap, the window edges, duplicates and a write while slots are held.
// It is followed by random traffic built mostly from shuffled runs of
// consecutive numbers. Both channels idle at random along the way.
// ----------------------------------------------------------------------------
module tb_sequence_reorder_buffer_unit;

  localparam int unsigned WINDOW       = 16;
  localparam int unsigned PAYLOAD_BITS = 32;
  localparam logic [srb_pkg::DataBits-1:0] PayMask =
    (PAYLOAD_BITS >= srb_pkg::DataBits) ? {srb_pkg::DataBits{1'b1}} :
                                          ((1 << PAYLOAD_BITS) - 1);
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned CycleLimit  = 400000;

  typedef struct {
    logic [srb_pkg::SeqBits-1:0]  seq;
    logic [srb_pkg::DataBits-1:0] word;
    srb_pkg::status_e             status;
    logic                         last;
  } release_t;

  logic                         clk_i        = 1'b0;
  logic                         rst_ni       = 1'b0;
  logic                         in_valid_i   = 1'b0;
  logic                         in_ready_o;
  logic [srb_pkg::SeqBits-1:0]  seq_number_i = '0;
  logic [srb_pkg::DataBits-1:0] payload_i    = '0;
  logic                         out_valid_o;
  logic                         out_ready_i  = 1'b0;
  logic [srb_pkg::SeqBits-1:0]  out_seq_number_o;
  logic [srb_pkg::DataBits-1:0] out_payload_o;
  logic [1:0]                   status_o;
  logic                         last_o;
  logic                         cfg_we_i     = 1'b0;
  logic [srb_pkg::SeqBits-1:0]  cfg_wdata_i  = '0;

  // Predicted buffer state.
  logic [srb_pkg::SeqBits-1:0]  exp_next_seq  = '0;
  logic                         slot_held [WINDOW];
  logic [srb_pkg::DataBits-1:0] slot_word [WINDOW];
  int unsigned                  ring_head = 0;

  release_t    expected_results[$];
  int unsigned order[WINDOW];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          gaps_on     = 1'b0;
  int unsigned burst_left  = 0;

  sequence_reorder_buffer_unit #(
    .WINDOW      (WINDOW),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .seq_number_i    (seq_number_i),
    .payload_i       (payload_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_seq_number_o(out_seq_number_o),
    .out_payload_o   (out_payload_o),
    .status_o        (status_o),
    .last_o          (last_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    for (int i = 0; i < WINDOW; i++) begin
      slot_held[i] = 1'b0;
      slot_word[i] = '0;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // The receiver switches at random between always ready, coin-toss, a fixed
  // duty pattern and mostly stalled.
  always @(negedge clk_i) begin
    int unsigned rx_mode;
    if (cycle_count % 256 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      2: out_ready_i <= (cycle_count % 5) < 2;
      default: out_ready_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    release_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result seq %h payload %h status %0d last %b",
                 $time, out_seq_number_o, out_payload_o, status_o, last_o);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_seq_number_o !== want.seq) begin
          $display("%0t: seq expected %h actual %h", $time, want.seq, out_seq_number_o);
          error_count++;
        end
        if (out_payload_o !== want.word) begin
          $display("%0t: payload expected %h actual %h", $time, want.word, out_payload_o);
          error_count++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          error_count++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, last_o);
          error_count++;
        end
      end
    end
  end

  // Stores the request if it falls in the window, flags it otherwise, then
  // releases consecutive held packets from the head of the ring, up to the burst cap.
  task automatic predict_request(input logic [srb_pkg::SeqBits-1:0] seq,
                                 input logic [srb_pkg::DataBits-1:0] pay);
    logic [srb_pkg::SeqBits-1:0] d;
    int unsigned                 idx;
    release_t                    r;
    release_t                    batch[$];
    d = seq - exp_next_seq;
    if (d < WINDOW) begin
      idx = (ring_head + d) % WINDOW;
      slot_held[idx] = 1'b1;
      slot_word[idx] = pay & PayMask;
      if (d != 0) begin
        r = '{seq: seq, word: '0, status: srb_pkg::ST_HELD, last: 1'b0};
        batch.push_back(r);
      end
    end else begin
      r = '{seq: seq, word: '0,
            status: d[srb_pkg::SeqBits-1] ? srb_pkg::ST_STALE : srb_pkg::ST_BEYOND,
            last: 1'b0};
      batch.push_back(r);
    end
    while (batch.size() < srb_pkg::MaxOut && slot_held[ring_head]) begin
      r = '{seq: exp_next_seq, word: slot_word[ring_head], status: srb_pkg::ST_RELEASED,
            last: 1'b0};
      batch.push_back(r);
      slot_held[ring_head] = 1'b0;
      slot_word[ring_head] = '0;
      exp_next_seq = exp_next_seq + 1;
      ring_head = (ring_head + 1) % WINDOW;
    end
    batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) expected_results.push_back(batch[i]);
  endtask

  // Called at a falling edge; returns at a falling edge after acceptance.
  task automatic send_request(input logic [srb_pkg::SeqBits-1:0] seq,
                              input logic [srb_pkg::DataBits-1:0] pay);
    in_valid_i   = 1'b1;
    seq_number_i = seq;
    payload_i    = pay;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_request(seq, pay);
    @(negedge clk_i);
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_valid_i = 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
        burst_left = $urandom_range(1, 8);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_start_sequence(input logic [srb_pkg::SeqBits-1:0] value);
    bit busy;
    wait_drained();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(posedge clk_i);
    busy = 1'b0;
    for (int i = 0; i < WINDOW; i++) busy |= slot_held[i];
    if (!busy) exp_next_seq = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic shuffle_offsets(input int unsigned count);
    int unsigned j;
    int unsigned tmp;
    for (int i = 0; i < count; i++) order[i] = i;
    for (int i = count - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
  endtask

  task automatic test_in_order();
    send_request(32'h0000_0000, 32'h0000_0000);
    send_request(32'h0000_0001, 32'hFFFF_FFFF);
  endtask

  task automatic test_wrap();
    write_start_sequence(32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, $urandom);
    send_request(32'h0000_0000, $urandom);
  endtask

  task automatic test_out_of_window();
    send_request(exp_next_seq - 1, $urandom);
    send_request(exp_next_seq + 32'h8000_0000, $urandom);
    send_request(exp_next_seq + WINDOW, $urandom);
    send_request(exp_next_seq + 32'h7FFF_FFFF, $urandom);
  endtask

  // Fills every slot but the head in random order, overwrites the far edge,
  // writes the register while slots are held, then releases all sixteen.
  task automatic test_full_window();
    logic [srb_pkg::SeqBits-1:0] base;
    base = exp_next_seq;
    shuffle_offsets(WINDOW);
    for (int i = 0; i < WINDOW; i++) begin
      if (order[i] != 0) send_request(base + order[i], $urandom);
    end
    send_request(base + WINDOW - 1, 32'hA5A5_5A5A);
    write_start_sequence(32'h0000_0000);
    send_request(base, $urandom);
  endtask

  // Mostly shuffled runs of consecutive numbers from the expected one, some
  // with a hole that a later run fills, mixed with stale, beyond and noise.
  task automatic test_random_traffic(input int unsigned n_items, input bit with_gaps);
    int unsigned                 sent;
    int unsigned                 k;
    int unsigned                 skip;
    int unsigned                 pick;
    logic [srb_pkg::SeqBits-1:0] base;
    gaps_on    = with_gaps;
    burst_left = $urandom_range(1, 8);
    sent       = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        base = exp_next_seq;
        k    = $urandom_range(1, WINDOW);
        skip = ($urandom_range(0, 3) == 0) ? $urandom_range(0, k - 1) : WINDOW;
        shuffle_offsets(k);
        for (int i = 0; i < k; i++) begin
          if (order[i] != skip) begin
            send_request(base + order[i], $urandom);
            sent++;
          end
        end
        if ($urandom_range(0, 4) == 0) begin
          send_request(base + $urandom_range(0, k - 1), $urandom);
          sent++;
        end
      end else if (pick == 7) begin
        send_request(exp_next_seq + {1'b1, 31'($urandom)}, $urandom);
        sent++;
      end else if (pick == 8) begin
        send_request(exp_next_seq + $urandom_range(WINDOW, 32'h7FFF_FFFF), $urandom);
        sent++;
      end else begin
        send_request($urandom, $urandom);
        sent++;
      end
    end
  endtask

  initial begin
    logic [srb_pkg::SeqBits-1:0] starts[5];
    starts = '{32'hFFFF_FFF8, $urandom, 32'h7FFF_FFFF, 32'h0000_0000, $urandom};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_in_order();
    test_wrap();
    test_out_of_window();
    test_full_window();
    for (int p = 0; p < 5; p++) begin
      write_start_sequence(starts[p]);
      test_random_traffic(100, p % 2 == 1);
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/srb_pkg.sv
sv/srb_ctrl.sv
sv/srb_dp.sv
sv/sequence_reorder_buffer_unit.sv
test/tb_sequence_reorder_buffer_unit.sv
